// ----- rtl/rpir_pkg.sv -----
// ----------------------------------------------------------------------------
// rpir_pkg: shared types and constants for the radix-prefixed integer reader
// Character codes, the classified character item, the result entry and the
// parser phase encoding.
// ----------------------------------------------------------------------------
package rpir_pkg;

   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_Z  = 8'h5a;
   localparam logic [7:0] CHAR_A     = 8'h61;
   localparam logic [7:0] CHAR_F     = 8'h66;
   localparam logic [7:0] CHAR_B     = 8'h62;
   localparam logic [7:0] CHAR_O     = 8'h6f;
   localparam logic [7:0] CHAR_D     = 8'h64;
   localparam logic [7:0] CHAR_Z     = 8'h7a;
   localparam logic [7:0] CHAR_X     = 8'h78;
   localparam logic [7:0] CASE_GAP   = 8'h20;

   localparam logic [4:0] RADIX_NONE = 5'd0;
   localparam logic [4:0] RADIX_2    = 5'd2;
   localparam logic [4:0] RADIX_8    = 5'd8;
   localparam logic [4:0] RADIX_10   = 5'd10;
   localparam logic [4:0] RADIX_12   = 5'd12;
   localparam logic [4:0] RADIX_16   = 5'd16;

   localparam logic [4:0] DIGIT_NONE = 5'd16;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_type;

   typedef struct packed {
      logic               is_number;
      logic signed [63:0] value;
   } rsp_type;

   // one character after classification
   typedef struct packed {
      logic [4:0] digit;     // DIGIT_NONE when not a hex digit
      logic [4:0] prefix;    // RADIX_NONE when not a prefix letter
      logic       is_zero;
      logic       is_minus;
      logic       is_plus;
      logic       last;
   } item_type;

   // result as held in the output queue; sign applied on the way out
   typedef struct packed {
      logic        is_number;
      logic        negative;
      logic [63:0] magnitude;
   } res_type;

   typedef enum logic [2:0] {
      PHASE_START  = 3'd0,
      PHASE_BODY   = 3'd1,
      PHASE_ZERO   = 3'd2,
      PHASE_PREFIX = 3'd3,
      PHASE_DIGITS = 3'd4,
      PHASE_BAD    = 3'd5
   } phase_type;

endpackage

// ----- rtl/rpir_front.sv -----
// ----------------------------------------------------------------------------
// rpir_front: character intake and classification
// Decodes each byte into digit value, prefix radix and sign flags and holds
// it in a two-entry queue toward the parser.
// ----------------------------------------------------------------------------
module rpir_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  rpir_pkg::req_type  req_data,
   output logic               item_valid,
   output rpir_pkg::item_type item,
   input  logic               item_take
);

   logic [1:0]         count_ff, count_in;
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   rpir_pkg::item_type entry_ff [0:1];
   rpir_pkg::item_type cls;
   logic               wr_en;
   logic [7:0]         lower;

   // classification
   always_comb begin
      if (req_data.ch >= rpir_pkg::CHAR_UP_A && req_data.ch <= rpir_pkg::CHAR_UP_Z) begin
         lower = req_data.ch + rpir_pkg::CASE_GAP;
      end else begin
         lower = req_data.ch;
      end

      priority if (lower >= rpir_pkg::CHAR_0 && lower <= rpir_pkg::CHAR_9) begin
         cls.digit = 5'(lower - rpir_pkg::CHAR_0);
      end else if (lower >= rpir_pkg::CHAR_A && lower <= rpir_pkg::CHAR_F) begin
         cls.digit = 5'(lower - rpir_pkg::CHAR_A) + 5'd10;
      end else begin
         cls.digit = rpir_pkg::DIGIT_NONE;
      end

      priority if (lower == rpir_pkg::CHAR_B) begin
         cls.prefix = rpir_pkg::RADIX_2;
      end else if (lower == rpir_pkg::CHAR_O) begin
         cls.prefix = rpir_pkg::RADIX_8;
      end else if (lower == rpir_pkg::CHAR_D) begin
         cls.prefix = rpir_pkg::RADIX_10;
      end else if (lower == rpir_pkg::CHAR_Z) begin
         cls.prefix = rpir_pkg::RADIX_12;
      end else if (lower == rpir_pkg::CHAR_X) begin
         cls.prefix = rpir_pkg::RADIX_16;
      end else begin
         cls.prefix = rpir_pkg::RADIX_NONE;
      end

      cls.is_zero  = (req_data.ch == rpir_pkg::CHAR_0);
      cls.is_minus = (req_data.ch == rpir_pkg::CHAR_MINUS);
      cls.is_plus  = (req_data.ch == rpir_pkg::CHAR_PLUS);
      cls.last     = req_data.last;
   end

   assign full       = (count_ff == 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item       = entry_ff[rd_ptr_ff];
   assign wr_en      = push && !full;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ wr_en;
      rd_ptr_in = rd_ptr_ff ^ item_take;
      count_in  = count_ff + 2'(wr_en) - 2'(item_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= cls;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("front queue count out of range");

endmodule

// ----- rtl/rpir_back.sv -----
// ----------------------------------------------------------------------------
// rpir_back: token parser
// Walks the sign / prefix / digit phases, accumulates value * radix + digit
// and emits one result entry at the last character of a token.
// ----------------------------------------------------------------------------
module rpir_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  rpir_pkg::item_type item,
   output logic               item_take,
   input  logic               res_full,
   output logic               res_write,
   output rpir_pkg::res_type  res_entry
);

   rpir_pkg::phase_type phase_ff, phase_in;
   logic                negative_ff, negative_in;
   logic [4:0]          radix_ff, radix_in;
   logic [63:0]         acc_ff, acc_in;
   logic [63:0]         prod_sum;
   logic                digit_ok;
   logic                number_end;

   assign item_take = item_valid && (!item.last || !res_full);
   assign digit_ok  = (item.digit < radix_ff);
   assign prod_sum  = acc_ff * 64'(radix_ff) + 64'(item.digit);

   always_comb begin
      phase_in    = phase_ff;
      negative_in = negative_ff;
      radix_in    = radix_ff;
      acc_in      = acc_ff;

      // radix is ten and the accumulator zero in both START and BODY
      unique case (phase_ff)
         rpir_pkg::PHASE_START, rpir_pkg::PHASE_BODY: begin
            priority if (phase_ff == rpir_pkg::PHASE_START && item.is_minus) begin
               negative_in = 1'b1;
               phase_in    = rpir_pkg::PHASE_BODY;
            end else if (phase_ff == rpir_pkg::PHASE_START && item.is_plus) begin
               phase_in = rpir_pkg::PHASE_BODY;
            end else if (item.is_zero) begin
               acc_in   = '0;
               phase_in = rpir_pkg::PHASE_ZERO;
            end else if (digit_ok) begin
               acc_in   = prod_sum;
               phase_in = rpir_pkg::PHASE_DIGITS;
            end else begin
               phase_in = rpir_pkg::PHASE_BAD;
            end
         end
         rpir_pkg::PHASE_ZERO: begin
            priority if (item.prefix != rpir_pkg::RADIX_NONE) begin
               radix_in = item.prefix;
               acc_in   = '0;
               phase_in = rpir_pkg::PHASE_PREFIX;
            end else if (digit_ok) begin
               acc_in   = prod_sum;
               phase_in = rpir_pkg::PHASE_DIGITS;
            end else begin
               phase_in = rpir_pkg::PHASE_BAD;
            end
         end
         rpir_pkg::PHASE_PREFIX, rpir_pkg::PHASE_DIGITS: begin
            if (digit_ok) begin
               acc_in   = prod_sum;
               phase_in = rpir_pkg::PHASE_DIGITS;
            end else begin
               phase_in = rpir_pkg::PHASE_BAD;
            end
         end
         default: begin
            phase_in = rpir_pkg::PHASE_BAD;
         end
      endcase

      number_end = (phase_in == rpir_pkg::PHASE_ZERO) ||
                   (phase_in == rpir_pkg::PHASE_DIGITS);
      res_write              = item_take && item.last;
      res_entry.is_number    = number_end;
      res_entry.negative     = number_end && negative_in;
      res_entry.magnitude    = number_end ? acc_in : 64'd0;

      if (item.last) begin
         phase_in    = rpir_pkg::PHASE_START;
         negative_in = 1'b0;
         radix_in    = rpir_pkg::RADIX_10;
         acc_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= rpir_pkg::PHASE_START;
         negative_ff <= 1'b0;
         radix_ff    <= rpir_pkg::RADIX_10;
         acc_ff      <= '0;
      end else if (item_take) begin
         phase_ff    <= phase_in;
         negative_ff <= negative_in;
         radix_ff    <= radix_in;
         acc_ff      <= acc_in;
      end
   end

   a_start_clean: assert property (@(posedge clock) disable iff (reset)
      phase_ff == rpir_pkg::PHASE_START |->
         acc_ff == 64'd0 && !negative_ff && radix_ff == rpir_pkg::RADIX_10)
      else $error("token state not cleared at start");

   a_radix_legal: assert property (@(posedge clock) disable iff (reset)
      radix_ff == rpir_pkg::RADIX_2 || radix_ff == rpir_pkg::RADIX_8 ||
      radix_ff == rpir_pkg::RADIX_10 || radix_ff == rpir_pkg::RADIX_12 ||
      radix_ff == rpir_pkg::RADIX_16)
      else $error("radix register holds an illegal value");

endmodule

// ----- rtl/rpir_rsp_queue.sv -----
// ----------------------------------------------------------------------------
// rpir_rsp_queue: result queue
// Two-entry queue of finished results; the sign is applied on the way out.
// ----------------------------------------------------------------------------
module rpir_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              res_write,
   input  rpir_pkg::res_type res_entry,
   output logic              res_full,
   output logic              empty,
   input  logic              pop,
   output rpir_pkg::rsp_type rsp_data
);

   logic [1:0]        count_ff, count_in;
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   rpir_pkg::res_type entry_ff [0:1];
   rpir_pkg::res_type head;
   logic              rd_en;

   assign res_full = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign rd_en    = pop && !empty;
   assign head     = entry_ff[rd_ptr_ff];

   always_comb begin
      rsp_data.is_number = head.is_number;
      rsp_data.value     = head.negative ? $signed(64'd0 - head.magnitude)
                                         : $signed(head.magnitude);
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ res_write;
      rd_ptr_in = rd_ptr_ff ^ rd_en;
      count_in  = count_ff + 2'(res_write) - 2'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_write) begin
         entry_ff[wr_ptr_ff] <= res_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      res_write |-> !res_full)
      else $error("result written into a full queue");

endmodule

// ----- rtl/radix_prefixed_integer_reader.sv -----
// ----------------------------------------------------------------------------
// radix_prefixed_integer_reader: signed integer literal parser
// Parses an atom token, one character per transfer, into a signed 64-bit value.
// ----------------------------------------------------------------------------
// Characters are taken one per cycle while full is low, and a new token may
// follow the last character of the previous one with no gap. The rate is set
// by the parser's multiply-add of accumulator by radix, which completes one
// character a cycle unless a token's last character waits on a full result
// queue. A result reaches the result ports through both queues: the token's
// last character waits in the front queue until the parser reads it, and the
// parser writes the result into the result queue, where it waits until
// popped. The front and result queues are two entries deep each, so push
// keeps flowing while a result sits unpopped until both fill. Tokens without
// a leading '+'/'-' or a radix prefix read in decimal; a value that is not a
// number reads as zero with is_number low.
// ----------------------------------------------------------------------------
module radix_prefixed_integer_reader (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  rpir_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output rpir_pkg::rsp_type rsp_data
);

   logic               item_valid;
   logic               item_take;
   rpir_pkg::item_type item;
   logic               res_full;
   logic               res_write;
   rpir_pkg::res_type  res_entry;

   rpir_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   rpir_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .res_full   (res_full),
      .res_write  (res_write),
      .res_entry  (res_entry)
   );

   rpir_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .res_write (res_write),
      .res_entry (res_entry),
      .res_full  (res_full),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- bench/radix_prefixed_integer_reader_tb.sv -----
// ----------------------------------------------------------------------------
// radix_prefixed_integer_reader_tb: self-checking bench for the integer reader
// Feeds atom tokens one character per transfer. It starts with hand-picked
// tokens, then random well-formed literals, broken literals and byte noise.
// Each token result is checked against a predicted reading. Both sides pause
// at random, and the result side holds off once for long enough that the
// reader fills up and stalls its input.
// ----------------------------------------------------------------------------
module radix_prefixed_integer_reader_tb;

   localparam int CHAR_TARGET  = 400;
   localparam int CALM_FROM    = 320;   // no pauses on either side past this point
   localparam int HOLD_CYCLES  = 300;
   localparam int HOLD_AFTER   = 20;
   localparam int STALL_LIMIT  = 1500;
   localparam int MAX_REPORTED = 10;

   // Tracks the token being parsed and holds the expected readings in order.
   class literal_scoreboard;
      rpir_pkg::phase_type phase;
      logic                negative;
      logic [4:0]          radix;
      logic [63:0]         acc;
      rpir_pkg::rsp_type   expected_readings[$];
      int                  mismatches;
      int                  readings_checked;
      int                  numbers_seen;
      int                  rejects_seen;

      function new();
         clear_token();
         mismatches = 0;
         readings_checked = 0;
         numbers_seen = 0;
         rejects_seen = 0;
      endfunction

      function void clear_token();
         phase = rpir_pkg::PHASE_START;
         negative = 1'b0;
         radix = rpir_pkg::RADIX_10;
         acc = '0;
      endfunction

      function logic [7:0] fold_case(logic [7:0] c);
         if (c >= rpir_pkg::CHAR_UP_A && c <= rpir_pkg::CHAR_UP_Z) begin
            return c + rpir_pkg::CASE_GAP;
         end
         return c;
      endfunction

      function logic [4:0] digit_value(logic [7:0] c);
         logic [7:0] lc;
         lc = fold_case(c);
         if (lc >= rpir_pkg::CHAR_0 && lc <= rpir_pkg::CHAR_9) begin
            return 5'(lc - rpir_pkg::CHAR_0);
         end
         if (lc >= rpir_pkg::CHAR_A && lc <= rpir_pkg::CHAR_F) begin
            return 5'(lc - rpir_pkg::CHAR_A + 8'd10);
         end
         return rpir_pkg::DIGIT_NONE;
      endfunction

      function logic [4:0] prefix_radix(logic [7:0] c);
         case (fold_case(c))
            rpir_pkg::CHAR_B: return rpir_pkg::RADIX_2;
            rpir_pkg::CHAR_O: return rpir_pkg::RADIX_8;
            rpir_pkg::CHAR_D: return rpir_pkg::RADIX_10;
            rpir_pkg::CHAR_Z: return rpir_pkg::RADIX_12;
            rpir_pkg::CHAR_X: return rpir_pkg::RADIX_16;
            default: return rpir_pkg::RADIX_NONE;
         endcase
      endfunction

      function void take_digit(logic [7:0] c);
         logic [4:0] d;
         d = digit_value(c);
         if (d >= radix) begin
            phase = rpir_pkg::PHASE_BAD;
         end else begin
            acc = acc * 64'(radix) + 64'(d);
            phase = rpir_pkg::PHASE_DIGITS;
         end
      endfunction

      // a leading zero may still turn into a radix prefix
      function void take_first_digit(logic [7:0] c);
         if (c == rpir_pkg::CHAR_0) begin
            acc = '0;
            phase = rpir_pkg::PHASE_ZERO;
         end else begin
            take_digit(c);
         end
      endfunction

      function void accept_char(rpir_pkg::req_type item);
         logic [4:0]        r;
         rpir_pkg::rsp_type reading;
         case (phase)
            rpir_pkg::PHASE_START: begin
               radix = rpir_pkg::RADIX_10;
               acc = '0;
               negative = 1'b0;
               if (item.ch == rpir_pkg::CHAR_MINUS) begin
                  negative = 1'b1;
                  phase = rpir_pkg::PHASE_BODY;
               end else if (item.ch == rpir_pkg::CHAR_PLUS) begin
                  phase = rpir_pkg::PHASE_BODY;
               end else begin
                  take_first_digit(item.ch);
               end
            end
            rpir_pkg::PHASE_BODY: take_first_digit(item.ch);
            rpir_pkg::PHASE_ZERO: begin
               r = prefix_radix(item.ch);
               if (r != rpir_pkg::RADIX_NONE) begin
                  radix = r;
                  acc = '0;
                  phase = rpir_pkg::PHASE_PREFIX;
               end else begin
                  take_digit(item.ch);
               end
            end
            rpir_pkg::PHASE_PREFIX, rpir_pkg::PHASE_DIGITS: take_digit(item.ch);
            default: phase = rpir_pkg::PHASE_BAD;
         endcase
         if (item.last) begin
            reading.is_number = (phase == rpir_pkg::PHASE_ZERO ||
                                 phase == rpir_pkg::PHASE_DIGITS);
            if (reading.is_number) begin
               reading.value = negative ? 64'd0 - acc : acc;
               numbers_seen++;
            end else begin
               reading.value = '0;
               rejects_seen++;
            end
            expected_readings.push_back(reading);
            clear_token();
         end
      endfunction

      function void check_reading(rpir_pkg::rsp_type got);
         rpir_pkg::rsp_type want;
         readings_checked++;
         if (expected_readings.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTED) begin
               $display("unexpected result: is_number=%0b value=%0d",
                        got.is_number, got.value);
            end
            return;
         end
         want = expected_readings.pop_front();
         if (got.is_number !== want.is_number || got.value !== want.value) begin
            mismatches++;
            if (mismatches <= MAX_REPORTED) begin
               $display("mismatch: expected is_number=%0b value=%0d, %s",
                        want.is_number, want.value,
                        $sformatf("got is_number=%0b value=%0d",
                                  got.is_number, got.value));
            end
         end
      endfunction

      function int pending();
         return expected_readings.size();
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              push;
   logic              full;
   rpir_pkg::req_type req_data;
   logic              empty;
   logic              pop;
   rpir_pkg::rsp_type rsp_data;

   literal_scoreboard sb = new();
   int    chars_sent = 0;
   int    tokens_sent = 0;
   bit    bursts_on = 1'b1;
   bit    held_off = 1'b0;
   string hex_digits = "0123456789abcdef";
   string prefix_letters = "bodzx";
   logic [4:0] prefix_radices [5] = '{rpir_pkg::RADIX_2, rpir_pkg::RADIX_8,
                                      rpir_pkg::RADIX_10, rpir_pkg::RADIX_12,
                                      rpir_pkg::RADIX_16};

   radix_prefixed_integer_reader dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // push stays high between back-to-back transfers; only a pause lowers it
   task automatic send_item(rpir_pkg::req_type item);
      if (bursts_on && $urandom_range(0, 9) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      push <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (full);
      sb.accept_char(item);
      chars_sent++;
      if (item.last) tokens_sent++;
      if (chars_sent >= CALM_FROM) bursts_on = 1'b0;
   endtask

   task automatic send_text(string s);
      rpir_pkg::req_type item;
      for (int i = 0; i < s.len(); i++) begin
         item.ch = s[i];
         item.last = (i == s.len() - 1);
         send_item(item);
      end
   endtask

   task automatic send_random_token();
      logic [7:0]        text[$];
      int unsigned       kind;
      int unsigned       pick;
      int unsigned       ndig;
      logic [4:0]        base;
      logic [3:0]        d;
      logic [7:0]        c;
      rpir_pkg::req_type item;
      kind = $urandom_range(0, 19);
      if (kind >= 18) begin
         repeat ($urandom_range(1, 4)) text.push_back(8'($urandom_range(0, 255)));
      end else begin
         case ($urandom_range(0, 2))
            1: text.push_back(rpir_pkg::CHAR_PLUS);
            2: text.push_back(rpir_pkg::CHAR_MINUS);
            default: ;
         endcase
         base = rpir_pkg::RADIX_10;
         pick = $urandom_range(0, 5);
         if (pick != 0) begin
            c = prefix_letters[pick - 1];
            if ($urandom_range(0, 1) == 1) c = c - rpir_pkg::CASE_GAP;
            text.push_back(rpir_pkg::CHAR_0);
            text.push_back(c);
            base = prefix_radices[pick - 1];
         end
         // sign and prefix only, or mostly short digit runs with some long
         // enough to wrap
         if (kind >= 14 && kind < 16) begin
            ndig = 0;
         end else if ($urandom_range(0, 3) == 0) begin
            ndig = $urandom_range(12, 24);
         end else begin
            ndig = $urandom_range(1, 6);
         end
         repeat (ndig) begin
            d = 4'($urandom_range(0, base - 1));
            c = hex_digits[d];
            if (c >= rpir_pkg::CHAR_A && $urandom_range(0, 1) == 1) begin
               c = c - rpir_pkg::CASE_GAP;
            end
            text.push_back(c);
         end
         if (text.size() == 0) text.push_back(rpir_pkg::CHAR_MINUS);
         if (kind >= 16) text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
      end
      foreach (text[i]) begin
         item.ch = text[i];
         item.last = (i == text.size() - 1);
         send_item(item);
      end
   endtask

   // result side: random pauses, plus one long hold-off to back the reader up
   initial begin
      pop <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!held_off && sb.readings_checked >= HOLD_AFTER) begin
            held_off = 1'b1;
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (bursts_on && $urandom_range(0, 9) == 0) begin
            pop <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
         if (pop && !empty) sb.check_reading(rsp_data);
      end
   end

   // watchdog: cycles without any transfer on either side
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (push && !full) || (pop && !empty)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
         if (quiet >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      rpir_pkg::req_type item;
      int                errors;
      push <= 1'b0;
      req_data <= '0;
      reset <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // sign alone, lone zero, prefix with no digits, each radix, mixed case,
      // sign in the middle, NUL and high bytes
      send_text("+");
      send_text("-");
      send_text("0");
      send_text("09");
      send_text("0X");
      send_text("-0b101");
      send_text("0o17");
      send_text("0Zb");
      send_text("0xfF");
      send_text("9-");
      item.ch = 8'h00;
      item.last = 1'b1;
      send_item(item);
      item.ch = 8'hff;
      send_item(item);

      while (chars_sent < CHAR_TARGET) send_random_token();
      push <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      errors = sb.mismatches + sb.pending();
      $display("%0d characters in %0d tokens sent; %0d results checked",
               chars_sent, tokens_sent, sb.readings_checked);
      $display("%0d read as integers, %0d rejected; long result hold-off %s",
               sb.numbers_seen, sb.rejects_seen, held_off ? "done" : "not reached");
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
